// ----- rtl/ipv4udp_pkg.sv -----
`timescale 1ns / 1ps

package ipv4udp_pkg;

    // Frame geometry and header codes
    localparam int unsigned OFFSET_W = 7;
    localparam int unsigned LEN_W    = OFFSET_W + 1;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX     = '1;
    localparam logic [OFFSET_W-1:0] ETH_HDR_LEN    = 7'd14;
    localparam logic [LEN_W-1:0]    ETH_HDR_BYTES  = 8'd14;
    localparam logic [LEN_W-1:0]    IP_MIN_LEN     = 8'd20;
    localparam logic [LEN_W-1:0]    UDP_HDR_LEN    = 8'd8;
    localparam logic [15:0]         ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]          PROTO_UDP      = 8'd17;
    localparam logic [3:0]          IP_VERSION     = 4'd4;

    // Result status codes
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_INVALID     = 2'd1;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
    } out_word_t;

    // Header fields as they stand once the current byte has been captured
    typedef struct packed {
        logic [LEN_W-1:0] frame_len;
        logic [15:0]      ether_kind;
        logic [7:0]       version_and_length;
        logic [7:0]       proto_seen;
        logic [31:0]      source_seen;
        logic [31:0]      dest_seen;
        logic [31:0]      ports_seen;
    } hdr_fields_t;

endpackage

// ----- rtl/ipv4udp_capture.sv -----
`timescale 1ns / 1ps

module ipv4udp_capture (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     enable,
    input  ipv4udp_pkg::in_word_t    word,
    output ipv4udp_pkg::hdr_fields_t fields
);
    import ipv4udp_pkg::*;

    localparam logic [OFFSET_W-1:0] POS_ETYPE_HI = 7'd12;
    localparam logic [OFFSET_W-1:0] POS_ETYPE_LO = 7'd13;
    localparam logic [OFFSET_W-1:0] POS_PROTO    = 7'd23;
    localparam logic [OFFSET_W-1:0] POS_SRC_LO   = 7'd26;
    localparam logic [OFFSET_W-1:0] POS_SRC_HI   = 7'd29;
    localparam logic [OFFSET_W-1:0] POS_DST_LO   = 7'd30;
    localparam logic [OFFSET_W-1:0] POS_DST_HI   = 7'd33;
    localparam logic [OFFSET_W-1:0] PORTS_BYTES  = 7'd4;

    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [15:0]         ether_reg, ether_next;
    logic [7:0]          vl_reg, vl_next;
    logic [7:0]          proto_reg, proto_next;
    logic [31:0]         src_reg, src_next;
    logic [31:0]         dst_reg, dst_next;
    logic [31:0]         ports_reg, ports_next;
    logic [OFFSET_W-1:0] ports_start;
    logic                capture_en;

    // The UDP header starts right after the IPv4 header, whose length is IHL words.
    assign ports_start = ETH_HDR_LEN + {1'b0, vl_reg[3:0], 2'b00};
    assign capture_en  = enable && (offset_reg != OFFSET_MAX);

    always_comb begin
        ether_next = ether_reg;
        vl_next    = vl_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        ports_next = ports_reg;
        if (capture_en) begin
            if (offset_reg == POS_ETYPE_HI || offset_reg == POS_ETYPE_LO) begin
                ether_next = {ether_reg[7:0], word.data_byte};
            end
            if (offset_reg == ETH_HDR_LEN) begin
                vl_next = word.data_byte;
            end
            if (offset_reg == POS_PROTO) begin
                proto_next = word.data_byte;
            end
            if (offset_reg >= POS_SRC_LO && offset_reg <= POS_SRC_HI) begin
                src_next = {src_reg[23:0], word.data_byte};
            end
            if (offset_reg >= POS_DST_LO && offset_reg <= POS_DST_HI) begin
                dst_next = {dst_reg[23:0], word.data_byte};
            end
            if (offset_reg > ETH_HDR_LEN && offset_reg >= ports_start
                    && offset_reg < ports_start + PORTS_BYTES) begin
                ports_next = {ports_reg[23:0], word.data_byte};
            end
        end
    end

    always_comb begin
        offset_next = offset_reg;
        if (enable) begin
            if (word.last_byte) begin
                offset_next = '0;
            end else if (offset_reg != OFFSET_MAX) begin
                offset_next = offset_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            ether_reg  <= '0;
            vl_reg     <= '0;
            proto_reg  <= '0;
            src_reg    <= '0;
            dst_reg    <= '0;
            ports_reg  <= '0;
        end else begin
            offset_reg <= offset_next;
            ether_reg  <= ether_next;
            vl_reg     <= vl_next;
            proto_reg  <= proto_next;
            src_reg    <= src_next;
            dst_reg    <= dst_next;
            ports_reg  <= ports_next;
        end
    end

    assign fields.frame_len          = {1'b0, offset_reg} + 1'b1;
    assign fields.ether_kind         = ether_next;
    assign fields.version_and_length = vl_next;
    assign fields.proto_seen         = proto_next;
    assign fields.source_seen        = src_next;
    assign fields.dest_seen          = dst_next;
    assign fields.ports_seen         = ports_next;

    a_offset_clears_on_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        enable && word.last_byte |=> offset_reg == '0
    ) else $error("byte offset not cleared after the last word of a frame");

    a_offset_holds_when_idle: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !enable |=> $stable(offset_reg) && $stable(ports_reg) && $stable(vl_reg)
    ) else $error("capture state moved without a word being processed");

    a_offset_saturates: assert property (
        @(posedge aclk) disable iff (!aresetn)
        enable && !word.last_byte && offset_reg == OFFSET_MAX |=> offset_reg == OFFSET_MAX
    ) else $error("byte offset moved past its saturation point");

endmodule

// ----- rtl/ipv4udp_classify.sv -----
`timescale 1ns / 1ps

module ipv4udp_classify (
    input  ipv4udp_pkg::hdr_fields_t fields,
    output ipv4udp_pkg::out_word_t   result
);
    import ipv4udp_pkg::*;

    logic [LEN_W-1:0] ihl_bytes;
    logic [LEN_W-1:0] udp_end;
    logic [1:0]       status;

    assign ihl_bytes = {2'b00, fields.version_and_length[3:0], 2'b00};
    assign udp_end   = ETH_HDR_BYTES + ihl_bytes + UDP_HDR_LEN;

    // The checks are ordered: the first one that fails decides the status.
    always_comb begin
        if (fields.frame_len < ETH_HDR_BYTES) begin
            status = STATUS_INVALID;
        end else if (fields.ether_kind != ETHERTYPE_IPV4) begin
            status = STATUS_UNSUPPORTED;
        end else if (fields.frame_len < ETH_HDR_BYTES + IP_MIN_LEN
                || fields.version_and_length[7:4] != IP_VERSION) begin
            status = STATUS_INVALID;
        end else if (ihl_bytes < IP_MIN_LEN || fields.proto_seen != PROTO_UDP) begin
            status = STATUS_UNSUPPORTED;
        end else if (fields.frame_len < udp_end) begin
            status = STATUS_INVALID;
        end else begin
            status = STATUS_OK;
        end
    end

    always_comb begin
        result        = '0;
        result.status = status;
        if (status == STATUS_OK) begin
            result.saddr    = fields.source_seen;
            result.daddr    = fields.dest_seen;
            result.sport    = fields.ports_seen[31:16];
            result.dport    = fields.ports_seen[15:0];
            result.protocol = fields.proto_seen;
        end
    end

endmodule

// ----- rtl/ipv4_udp_five_tuple_extract.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Payload      Meaning
// s_       in         in_word_t    one frame byte per word, last_byte closes the frame
// m_       out        out_word_t   one status and five-tuple per frame
//
// One word is accepted per cycle unless a last word waits for a stalled result; an input
// register and a result register frame a single pass of capture and classification logic.
// A last word's result is taken into the result register once that register is free.
// Reset (aresetn, synchronous) empties both registers and clears the byte offset.
// A stalled result holds back only the next last word; other bytes keep flowing.

module ipv4_udp_five_tuple_extract (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ipv4udp_pkg::in_word_t  s_word,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ipv4udp_pkg::out_word_t m_word
);
    import ipv4udp_pkg::*;

    logic        in_vld_reg, in_vld_next;
    in_word_t    in_word_reg;
    logic        out_vld_reg, out_vld_next;
    out_word_t   out_word_reg;
    logic        out_free;
    logic        process;
    hdr_fields_t fields;
    out_word_t   result;

    assign out_free = !out_vld_reg || m_ready;
    // Only a last word needs room in the result register.
    assign process  = in_vld_reg && (!in_word_reg.last_byte || out_free);
    assign s_ready  = !in_vld_reg || process;

    ipv4udp_capture u_capture (
        .aclk    (aclk),
        .aresetn (aresetn),
        .enable  (process),
        .word    (in_word_reg),
        .fields  (fields)
    );

    ipv4udp_classify u_classify (
        .fields (fields),
        .result (result)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (process) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (process && in_word_reg.last_byte) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_word;
        end
        if (process && in_word_reg.last_byte) begin
            out_word_reg <= result;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_word  = out_word_reg;

    a_result_from_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(in_vld_reg && in_word_reg.last_byte)
    ) else $error("result raised without a last word being processed");

    a_ok_means_udp: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.status == STATUS_OK |-> m_word.protocol == PROTO_UDP
    ) else $error("accepted frame reported with a protocol other than UDP");

    a_error_zero_key: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.status != STATUS_OK |->
            m_word.saddr == '0 && m_word.daddr == '0 && m_word.sport == '0
            && m_word.dport == '0 && m_word.protocol == '0
    ) else $error("key fields not cleared on an error status");

    a_status_code: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_word.status == STATUS_OK || m_word.status == STATUS_INVALID
            || m_word.status == STATUS_UNSUPPORTED
    ) else $error("result status outside the defined codes");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import ipv4udp_pkg::*;

    // One row of the directed part describes a whole frame. A fill of -1 means random bytes.
    typedef struct packed {
        int          len;
        logic [15:0] etype;
        logic [7:0]  ver_ihl;
        logic [7:0]  proto;
        int          fill;
        bit          pinned;
        logic [1:0]  status;
    } frame_row_t;

    localparam int NUM_ROWS = 19;
    localparam frame_row_t FRAME_TABLE [NUM_ROWS] = '{
        '{1,   16'h0800, 8'h45, 8'd17, 0,   1'b1, STATUS_INVALID},
        '{13,  16'h0800, 8'h45, 8'd17, 255, 1'b1, STATUS_INVALID},
        '{14,  16'h86dd, 8'h45, 8'd17, 0,   1'b1, STATUS_UNSUPPORTED},
        '{14,  16'h0800, 8'h45, 8'd17, 0,   1'b1, STATUS_INVALID},
        '{44,  16'h86dd, 8'h45, 8'd17, 255, 1'b1, STATUS_UNSUPPORTED},
        '{33,  16'h0800, 8'h45, 8'd17, 0,   1'b1, STATUS_INVALID},
        '{44,  16'h0800, 8'h65, 8'd17, 0,   1'b1, STATUS_INVALID},
        '{44,  16'h0800, 8'h44, 8'd17, 0,   1'b1, STATUS_UNSUPPORTED},
        '{44,  16'h0800, 8'h40, 8'd17, 255, 1'b1, STATUS_UNSUPPORTED},
        '{44,  16'h0800, 8'h45, 8'd6,  0,   1'b1, STATUS_UNSUPPORTED},
        '{41,  16'h0800, 8'h45, 8'd17, 0,   1'b1, STATUS_INVALID},
        '{42,  16'h0800, 8'h45, 8'd17, 255, 1'b1, STATUS_OK},
        '{42,  16'h0800, 8'h45, 8'd17, 0,   1'b1, STATUS_OK},
        '{42,  16'h0800, 8'h4f, 8'd17, -1,  1'b1, STATUS_INVALID},
        '{81,  16'h0800, 8'h4f, 8'd17, -1,  1'b0, STATUS_OK},
        '{82,  16'h0800, 8'h4f, 8'd17, -1,  1'b0, STATUS_OK},
        '{34,  16'h0800, 8'h45, 8'd17, -1,  1'b0, STATUS_OK},
        '{128, 16'h0800, 8'h46, 8'd17, -1,  1'b0, STATUS_OK},
        '{140, 16'h0800, 8'h45, 8'd17, -1,  1'b0, STATUS_OK}
    };

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    // Parser state as the block should hold it.
    logic [OFFSET_W-1:0] frame_pos = '0;
    logic [15:0]         eth_type  = '0;
    logic [7:0]          ver_ihl   = '0;
    logic [7:0]          ip_proto  = '0;
    logic [31:0]         ip_src    = '0;
    logic [31:0]         ip_dst    = '0;
    logic [31:0]         udp_ports = '0;

    out_word_t   pending_tuples[$];
    logic [7:0]  frame_bytes[$];
    int          failures     = 0;
    int          bytes_sent   = 0;
    bit          hold_request = 1'b0;

    ipv4_udp_five_tuple_extract u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // Takes one accepted byte and returns the tuple that the frame yields if this byte closes it.
    function automatic out_word_t advance_parser(input logic [7:0] data, input logic is_last);
        int unsigned pos;
        int unsigned hdr_end;
        int unsigned len;
        int unsigned ihl_bytes;
        out_word_t   tuple;
        pos   = frame_pos;
        tuple = '0;
        if (frame_pos != OFFSET_MAX) begin
            if (pos == 12 || pos == 13) eth_type = {eth_type[7:0], data};
            if (pos == ETH_HDR_BYTES) ver_ihl = data;
            if (pos == 23) ip_proto = data;
            if (pos >= 26 && pos <= 29) ip_src = {ip_src[23:0], data};
            if (pos >= 30 && pos <= 33) ip_dst = {ip_dst[23:0], data};
            if (pos > ETH_HDR_BYTES) begin
                hdr_end = ETH_HDR_BYTES + int'(ver_ihl[3:0]) * 4;
                if (pos >= hdr_end && pos < hdr_end + 4) udp_ports = {udp_ports[23:0], data};
            end
        end
        if (!is_last) begin
            if (frame_pos != OFFSET_MAX) frame_pos = frame_pos + 1'b1;
            return tuple;
        end
        len       = pos + 1;
        frame_pos = '0;
        ihl_bytes = int'(ver_ihl[3:0]) * 4;
        if (len < ETH_HDR_BYTES)
            tuple.status = STATUS_INVALID;
        else if (eth_type != ETHERTYPE_IPV4)
            tuple.status = STATUS_UNSUPPORTED;
        else if (len < ETH_HDR_BYTES + IP_MIN_LEN || ver_ihl[7:4] != IP_VERSION)
            tuple.status = STATUS_INVALID;
        else if (ihl_bytes < IP_MIN_LEN || ip_proto != PROTO_UDP)
            tuple.status = STATUS_UNSUPPORTED;
        else if (len < ETH_HDR_BYTES + ihl_bytes + UDP_HDR_LEN)
            tuple.status = STATUS_INVALID;
        else
            tuple.status = STATUS_OK;
        if (tuple.status == STATUS_OK) begin
            tuple.saddr    = ip_src;
            tuple.daddr    = ip_dst;
            tuple.sport    = udp_ports[31:16];
            tuple.dport    = udp_ports[15:0];
            tuple.protocol = ip_proto;
        end
        return tuple;
    endfunction

    task automatic build_frame(input int len, input logic [15:0] etype, input logic [7:0] vi,
                               input logic [7:0] proto, input int fill);
        int         i;
        logic [7:0] data;
        frame_bytes.delete();
        for (i = 0; i < len; i++) begin
            data = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (i == 12) data = etype[15:8];
            if (i == 13) data = etype[7:0];
            if (i == 14) data = vi;
            if (i == 23) data = proto;
            frame_bytes.push_back(data);
        end
    endtask

    task automatic put_word(input logic [7:0] data, input logic is_last, input int gap,
                            input bit pinned, input out_word_t pinned_tuple);
        out_word_t predicted;
        in_word_t  word;
        word.data_byte = data;
        word.last_byte = is_last;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        predicted = advance_parser(data, is_last);
        if (is_last) pending_tuples.push_back(pinned ? pinned_tuple : predicted);
    endtask

    task automatic send_frame(input bit pinned, input out_word_t pinned_tuple, input bit burst);
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
            put_word(frame_bytes[i], i == frame_bytes.size() - 1,
                     burst ? 0 : $urandom_range(0, 18), pinned, pinned_tuple);
    endtask

    // Mostly well-formed UDP frames with random content; the rest are damaged or pure noise.
    task automatic random_frame();
        int          ihl;
        int          need;
        int          len;
        int          shape;
        logic [15:0] etype;
        logic [7:0]  vi;
        logic [7:0]  proto;
        ihl   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
        need  = 14 + ihl * 4 + 8;
        len   = need + $urandom_range(0, 24);
        if ($urandom_range(0, 19) == 0) len = $urandom_range(120, 200);
        etype = ETHERTYPE_IPV4;
        vi    = {IP_VERSION, 4'(ihl)};
        proto = PROTO_UDP;
        shape = $urandom_range(0, 9);
        if (shape == 7) begin
            case ($urandom_range(0, 4))
                0: etype = 16'($urandom);
                1: vi[7:4] = 4'($urandom);
                2: vi[3:0] = 4'($urandom_range(0, 4));
                3: proto = 8'($urandom);
                default: len = $urandom_range(1, need - 1);
            endcase
        end else if (shape >= 8) begin
            len   = $urandom_range(1, 48);
            etype = 16'($urandom);
            vi    = 8'($urandom);
            proto = 8'($urandom);
        end
        build_frame(len, etype, vi, proto, -1);
        send_frame(1'b0, '0, $urandom_range(0, 3) == 0);
    endtask

    initial begin
        int         r;
        frame_row_t row;
        out_word_t  typed;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (r = 0; r < NUM_ROWS; r++) begin
            row = FRAME_TABLE[r];
            build_frame(row.len, row.etype, row.ver_ihl, row.proto, row.fill);
            typed        = '0;
            typed.status = row.status;
            if (row.status == STATUS_OK) begin
                typed.saddr    = {4{row.fill[7:0]}};
                typed.daddr    = {4{row.fill[7:0]}};
                typed.sport    = {2{row.fill[7:0]}};
                typed.dport    = {2{row.fill[7:0]}};
                typed.protocol = PROTO_UDP;
            end
            send_frame(row.pinned, typed, r[0]);
        end
        s_valid <= 1'b0;

        // Let the block drain completely, then stall the result side while tiny frames
        // pile up behind it.
        while (pending_tuples.size() != 0) @(posedge aclk);
        hold_request = 1'b1;
        repeat (12) begin
            build_frame($urandom_range(1, 3), ETHERTYPE_IPV4, 8'h45, PROTO_UDP, -1);
            send_frame(1'b0, '0, 1'b1);
        end

        while (bytes_sent < 1150) random_frame();
        s_valid <= 1'b0;

        while (pending_tuples.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (failures == 0 && pending_tuples.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial begin
        int stall;
        bit no_stalls;
        no_stalls = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            if ($urandom_range(0, 15) == 0) no_stalls = !no_stalls;
            stall = no_stalls ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_tuples.size() == 0) begin
                $error("result word with none expected, status %0d", m_word.status);
                failures++;
            end else begin
                want = pending_tuples.pop_front();
                check_field("status",   32'(want.status),   32'(m_word.status));
                check_field("saddr",    want.saddr,         m_word.saddr);
                check_field("daddr",    want.daddr,         m_word.daddr);
                check_field("sport",    32'(want.sport),    32'(m_word.sport));
                check_field("dport",    32'(want.dport),    32'(m_word.dport));
                check_field("protocol", 32'(want.protocol), 32'(m_word.protocol));
            end
        end
    end

endmodule

// ----- files.f -----
rtl/ipv4udp_pkg.sv
rtl/ipv4udp_capture.sv
rtl/ipv4udp_classify.sv
rtl/ipv4_udp_five_tuple_extract.sv
tb/sv/tb.sv
